// File: rtl/hst_pkg.sv
// shared types, constants and helper functions of the hotkey switch tracker
`default_nettype none
package hst_pkg;

  localparam int PRESSED_DEPTH = 16;
  localparam int BINDING_SLOTS = 4;
  localparam int HOLD_DEPTH    = 4;
  localparam int SLOT_W        = $clog2(BINDING_SLOTS);
  localparam int CFG_W         = 25;
  localparam int CFG_IDX_W     = 3;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(BINDING_SLOTS - 1);

  // modifier scan codes
  localparam logic [15:0] SC_CTRL   = 16'h001D;
  localparam logic [15:0] SC_LSHIFT = 16'h002A;
  localparam logic [15:0] SC_RSHIFT = 16'h0036;
  localparam logic [15:0] SC_ALT    = 16'h0038;
  localparam logic [15:0] SC_LWIN   = 16'h005B;
  localparam logic [15:0] SC_RWIN   = 16'h005C;

  localparam logic [3:0] MOD_CTRL  = 4'd1;
  localparam logic [3:0] MOD_ALT   = 4'd2;
  localparam logic [3:0] MOD_SHFT  = 4'd4;
  localparam logic [3:0] MOD_WIN   = 4'd8;

  typedef enum logic [1:0] {
    CMD_KEY   = 2'd0,
    CMD_TRIG  = 2'd1,
    CMD_RESET = 2'd2,
    CMD_LOAD  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_EN   = 2'd0,
    OP_DIS  = 2'd1,
    OP_TOG  = 2'd2,
    OP_HOLD = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_SNAP     = 2'd0,
    ST_HOLD_REJ = 2'd1,
    ST_FULL     = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VIS   = 3'd0,
    CFG_INIT  = 3'd1,
    CFG_BIND0 = 3'd2,
    CFG_BIND1 = 3'd3,
    CFG_BIND2 = 3'd4,
    CFG_BIND3 = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] scan;
    logic        ext;
  } key_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  op;
    logic        target;
    logic [3:0]  mods;
    logic        ext;
    logic [15:0] scan;
  } binding_t;

  typedef struct packed {
    logic valid;
    key_t key;
    logic target;
  } hold_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] key_scan;
    logic        extended;
    logic        pressed;
    logic        trigger_target;
    logic [1:0]  trigger_operation;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       switch_a_on;
    logic       switch_b_on;
    logic       visible;
  } out_item_t;

  typedef struct packed {
    logic [1:0]                    vis_rule;
    logic [1:0]                    init_sw;
    binding_t [BINDING_SLOTS-1:0]  binding;
  } cfg_t;

  // pressed store control from the sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic inv_en;
    logic clr;
    key_t wr_key;
  } pk_cmd_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] slot;
  } mslot_t;

  function automatic mslot_t mod_slot(logic [15:0] scan, logic ext);
    mslot_t r;
    r = '0;
    if (scan == SC_CTRL) begin
      r.hit  = 1'b1;
      r.slot = ext ? 3'd1 : 3'd0;
    end else if (!ext && scan == SC_LSHIFT) begin
      r.hit  = 1'b1;
      r.slot = 3'd2;
    end else if (!ext && scan == SC_RSHIFT) begin
      r.hit  = 1'b1;
      r.slot = 3'd3;
    end else if (scan == SC_ALT) begin
      r.hit  = 1'b1;
      r.slot = ext ? 3'd5 : 3'd4;
    end else if (ext && scan == SC_LWIN) begin
      r.hit  = 1'b1;
      r.slot = 3'd6;
    end else if (ext && scan == SC_RWIN) begin
      r.hit  = 1'b1;
      r.slot = 3'd7;
    end
    return r;
  endfunction

  function automatic logic [3:0] mod_bit(logic [2:0] slot);
    logic [3:0] m;
    case (slot[2:1])
      2'd0:    m = MOD_CTRL;
      2'd1:    m = MOD_SHFT;
      2'd2:    m = MOD_ALT;
      default: m = MOD_WIN;
    endcase
    return m;
  endfunction

  function automatic logic [3:0] mods_of_held(logic [7:0] held);
    logic [3:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (held[i]) m = m | mod_bit(3'(i));
    end
    return m;
  endfunction

  function automatic logic apply_op(logic cur, logic [1:0] op);
    logic r;
    case (op)
      OP_DIS:  r = 1'b0;
      OP_TOG:  r = ~cur;
      default: r = 1'b1;
    endcase
    return r;
  endfunction

  function automatic logic visible_of(logic [1:0] rule, logic a, logic b);
    logic r;
    case (rule)
      2'd0:    r = a;
      2'd1:    r = b;
      2'd2:    r = a & b;
      default: r = a | b;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/hst_if.sv
// valid/ready channels for input items and result items
`default_nettype none
interface hst_in_if;
  import hst_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface hst_out_if;
  import hst_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface
`default_nettype wire

// File: rtl/hst_pressed_store.sv
// store of pressed physical keys: key memory with registered read, valid flops
`default_nettype none
module hst_pressed_store #(
  parameter int DEPTH = hst_pkg::PRESSED_DEPTH
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  hst_pkg::pk_cmd_t        cmd_i,
  input  wire [$clog2(DEPTH)-1:0] rd_addr_i,
  input  wire [$clog2(DEPTH)-1:0] wr_addr_i,
  output hst_pkg::key_t           rd_key_o,
  output logic                    rd_valid_o
);
  import hst_pkg::*;

  key_t             mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  key_t             rd_key_q;
  logic             rd_valid_q;

  // key memory, written on insert
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem[wr_addr_i] <= cmd_i.wr_key;
    if (cmd_i.rd_en) rd_key_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        valid_q <= '0;
      end else if (cmd_i.wr_en) begin
        valid_q[wr_addr_i] <= 1'b1;
      end else if (cmd_i.inv_en) begin
        valid_q[wr_addr_i] <= 1'b0;
      end
      if (cmd_i.rd_en) rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  assign rd_key_o   = rd_key_q;
  assign rd_valid_o = rd_valid_q;

  a_one_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((cmd_i.wr_en && cmd_i.inv_en) || (cmd_i.clr && cmd_i.wr_en)))
    else $error("pressed store got conflicting updates");

  a_clr_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr |=> valid_q == '0)
    else $error("pressed store not empty after clear");

  a_wr_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en |=> valid_q[$past(wr_addr_i)])
    else $error("inserted key not marked valid");

endmodule
`default_nettype wire

// File: rtl/hst_engine.sv
// sequencer with one shared key comparator: store scan, binding match, hold release
`default_nettype none
module hst_engine #(
  parameter int DEPTH = hst_pkg::PRESSED_DEPTH
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  hst_pkg::cfg_t            cfg_i,
  input  wire                      item_valid_i,
  input  hst_pkg::in_item_t        item_i,
  output logic                     item_ready_o,
  output logic                     res_valid_o,
  input  wire                      res_ready_i,
  output hst_pkg::out_item_t       res_o,
  output hst_pkg::pk_cmd_t         pk_cmd_o,
  output logic [$clog2(DEPTH)-1:0] pk_rd_addr_o,
  output logic [$clog2(DEPTH)-1:0] pk_wr_addr_o,
  input  hst_pkg::key_t            pk_key_i,
  input  wire                      pk_valid_i
);
  import hst_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_BIND,
    S_HREL,
    S_OUT
  } state_e;

  state_e            state_q;
  key_t              key_q;
  logic              pressed_q;
  logic [3:0]        mods_q;
  logic [7:0]        held_q;
  logic              sw_a_q;
  logic              sw_b_q;
  hold_t             hold_q [HOLD_DEPTH];
  logic [AW-1:0]     idx_q;
  logic              issue_done_q;
  logic              pv_q;
  logic [AW-1:0]     pidx_q;
  logic              found_q;
  logic [AW-1:0]     found_idx_q;
  logic              free_q;
  logic [AW-1:0]     free_idx_q;
  logic [SLOT_W-1:0] step_q;
  logic [1:0]        status_q;

  mslot_t     ms;
  logic [3:0] mods_d;
  key_t       in_key;

  // shared comparator
  key_t       cand_key;
  logic [3:0] cand_mods;
  logic       cand_ok;
  logic       hit;

  binding_t   b_sel;
  logic       b_old, b_new;
  hold_t      h_sel;
  logic       h_old;
  logic       t_old, t_new;
  logic       clr_a, clr_b, rst_changed;
  logic       ins_ok;
  logic [SLOT_W-1:0] ins_idx;
  logic       dup_hold;

  assign in_key = '{scan: item_i.key_scan, ext: item_i.extended};
  assign ms     = mod_slot(item_i.key_scan, item_i.extended);
  assign mods_d = ms.hit ? (mods_of_held(held_q) & ~mod_bit(ms.slot)) : mods_of_held(held_q);

  assign b_sel = cfg_i.binding[step_q];
  assign h_sel = hold_q[step_q];

  always_comb begin
    unique case (state_q)
      S_BIND: begin
        cand_key  = '{scan: b_sel.scan, ext: b_sel.ext};
        cand_mods = b_sel.mods;
        cand_ok   = b_sel.valid;
      end
      S_HREL: begin
        cand_key  = h_sel.key;
        cand_mods = mods_q;
        cand_ok   = h_sel.valid;
      end
      default: begin
        cand_key  = pk_key_i;
        cand_mods = mods_q;
        cand_ok   = pk_valid_i;
      end
    endcase
  end

  assign hit = cand_ok && (cand_key == key_q) && (cand_mods == mods_q);

  assign b_old = b_sel.target ? sw_b_q : sw_a_q;
  assign b_new = apply_op(b_old, b_sel.op);
  assign h_old = h_sel.target ? sw_b_q : sw_a_q;
  assign t_old = item_i.trigger_target ? sw_b_q : sw_a_q;
  assign t_new = apply_op(t_old, item_i.trigger_operation);

  always_comb begin
    clr_a   = 1'b0;
    clr_b   = 1'b0;
    ins_ok  = 1'b0;
    ins_idx = '0;
    for (int h = 0; h < HOLD_DEPTH; h++) begin
      if (hold_q[h].valid && !hold_q[h].target) clr_a = 1'b1;
      if (hold_q[h].valid && hold_q[h].target) clr_b = 1'b1;
      if (!hold_q[h].valid && !ins_ok) begin
        ins_ok  = 1'b1;
        ins_idx = SLOT_W'(h);
      end
    end
  end

  assign rst_changed = (clr_a && sw_a_q) || (clr_b && sw_b_q);

  // pressed store control
  always_comb begin
    pk_cmd_o        = '0;
    pk_cmd_o.wr_key = key_q;
    pk_cmd_o.rd_en  = (state_q == S_SCAN) && !issue_done_q;
    pk_rd_addr_o    = idx_q;
    pk_wr_addr_o    = pressed_q ? free_idx_q : found_idx_q;
    if (state_q == S_DECIDE) begin
      pk_cmd_o.wr_en  = pressed_q && !found_q && free_q;
      pk_cmd_o.inv_en = !pressed_q && found_q;
    end
    if (state_q == S_IDLE && item_valid_i &&
        (item_i.command == CMD_RESET || item_i.command == CMD_LOAD)) begin
      pk_cmd_o.clr = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      key_q        <= '0;
      pressed_q    <= 1'b0;
      mods_q       <= '0;
      held_q       <= '0;
      sw_a_q       <= 1'b0;
      sw_b_q       <= 1'b0;
      for (int h = 0; h < HOLD_DEPTH; h++) hold_q[h] <= '0;
      idx_q        <= '0;
      issue_done_q <= 1'b0;
      pv_q         <= 1'b0;
      pidx_q       <= '0;
      found_q      <= 1'b0;
      found_idx_q  <= '0;
      free_q       <= 1'b0;
      free_idx_q   <= '0;
      step_q       <= '0;
      status_q     <= ST_SNAP;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (item_valid_i) begin
            unique case (item_i.command)
              CMD_KEY: begin
                status_q     <= ST_SNAP;
                key_q        <= in_key;
                pressed_q    <= item_i.pressed;
                mods_q       <= mods_d;
                if (ms.hit) held_q[ms.slot] <= item_i.pressed;
                idx_q        <= '0;
                issue_done_q <= 1'b0;
                pv_q         <= 1'b0;
                found_q      <= 1'b0;
                free_q       <= 1'b0;
                state_q      <= S_SCAN;
              end
              CMD_TRIG: begin
                if (item_i.trigger_operation == OP_HOLD) begin
                  status_q <= ST_HOLD_REJ;
                  state_q  <= S_OUT;
                end else begin
                  status_q <= ST_SNAP;
                  if (item_i.trigger_target) sw_b_q <= t_new;
                  else                       sw_a_q <= t_new;
                  state_q <= (t_new != t_old) ? S_OUT : S_IDLE;
                end
              end
              CMD_RESET: begin
                status_q <= ST_SNAP;
                held_q   <= '0;
                for (int h = 0; h < HOLD_DEPTH; h++) hold_q[h].valid <= 1'b0;
                if (clr_a) sw_a_q <= 1'b0;
                if (clr_b) sw_b_q <= 1'b0;
                state_q <= rst_changed ? S_OUT : S_IDLE;
              end
              default: begin
                status_q <= ST_SNAP;
                held_q   <= '0;
                for (int h = 0; h < HOLD_DEPTH; h++) hold_q[h].valid <= 1'b0;
                sw_a_q  <= cfg_i.init_sw[0];
                sw_b_q  <= cfg_i.init_sw[1];
                state_q <= S_OUT;
              end
            endcase
          end
        end
        S_SCAN: begin
          // read one entry a cycle, compare it in the cycle after its read
          if (!issue_done_q) begin
            idx_q <= idx_q + AW'(1);
            if (idx_q == LAST) issue_done_q <= 1'b1;
          end
          pv_q   <= !issue_done_q;
          pidx_q <= idx_q;
          if (pv_q) begin
            if (hit && !found_q) begin
              found_q     <= 1'b1;
              found_idx_q <= pidx_q;
            end
            if (!pk_valid_i && !free_q) begin
              free_q     <= 1'b1;
              free_idx_q <= pidx_q;
            end
            if (pidx_q == LAST) state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          step_q <= '0;
          if (pressed_q) begin
            if (found_q) begin
              state_q <= S_IDLE;
            end else if (!free_q) begin
              status_q <= ST_FULL;
              state_q  <= S_OUT;
            end else begin
              state_q <= S_BIND;
            end
          end else begin
            state_q <= S_HREL;
          end
        end
        S_BIND: begin
          if (hit) begin
            if (b_sel.op == OP_HOLD && ins_ok) begin
              hold_q[ins_idx] <= '{valid: 1'b1, key: key_q, target: b_sel.target};
            end
            if (b_sel.target) sw_b_q <= b_new;
            else              sw_a_q <= b_new;
            state_q <= (b_new != b_old) ? S_OUT : S_IDLE;
          end else if (step_q == SLOT_LAST) begin
            state_q <= S_IDLE;
          end else begin
            step_q <= step_q + SLOT_W'(1);
          end
        end
        S_HREL: begin
          if (hit) begin
            hold_q[step_q].valid <= 1'b0;
            if (h_sel.target) sw_b_q <= 1'b0;
            else              sw_a_q <= 1'b0;
            state_q <= h_old ? S_OUT : S_IDLE;
          end else if (step_q == SLOT_LAST) begin
            state_q <= S_IDLE;
          end else begin
            step_q <= step_q + SLOT_W'(1);
          end
        end
        S_OUT: begin
          if (res_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign item_ready_o       = (state_q == S_IDLE);
  assign res_valid_o        = (state_q == S_OUT);
  assign res_o.status       = status_q;
  assign res_o.switch_a_on  = sw_a_q;
  assign res_o.switch_b_on  = sw_b_q;
  assign res_o.visible      = visible_of(cfg_i.vis_rule, sw_a_q, sw_b_q);

  always_comb begin
    dup_hold = 1'b0;
    for (int i = 0; i < HOLD_DEPTH; i++) begin
      for (int j = i + 1; j < HOLD_DEPTH; j++) begin
        if (hold_q[i].valid && hold_q[j].valid && hold_q[i].key == hold_q[j].key) begin
          dup_hold = 1'b1;
        end
      end
    end
  end

  a_decide_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECIDE) |-> ($past(state_q) == S_SCAN))
    else $error("decision without a completed store scan");

  a_no_dup_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !dup_hold)
    else $error("same key recorded twice as a hold");

  a_full_only_no_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == ST_FULL) |-> (pressed_q && !free_q && !found_q))
    else $error("store full reported with a free entry");

endmodule
`default_nettype wire

// File: rtl/hotkey_switch_tracker_top.sv
// top level of the hotkey switch tracker: config registers, engine, store, output register
//
// Usage:
//  - in_i carries one item per command: key make/break, hotkey trigger, reset keys
//    or load configuration. in_i.ready is high only while the sequencer is idle.
//  - out_o carries at most one result item per input item: a switch snapshot,
//    a rejected hold trigger, or a pressed store full flag, always with both
//    switches and the visibility from the current rule.
//  - configuration is a write-only port (cfg_we_i, cfg_idx_i, cfg_wdata_i); unknown
//    indexes are ignored; the user writes it only while no item is in flight, unchecked.
// Sequencing:
//  - triggers, reset keys and load are handled in the sequencer's idle state; a key
//    event reads the pressed store one entry a cycle through its registered read port,
//    then steps through up to four binding slots or holds for the binding or hold match,
//    one shared comparator step per cycle.
//  - a result is registered in the output register before it reaches out_o.
// Reset clears switches, held modifiers, pressed keys, holds and registers.
// When the receiver stalls, the result waits in the output register and
// the sequencer holds its next result until the register frees up.
`default_nettype none
module hotkey_switch_tracker_top #(
  parameter int PRESSED_DEPTH = hst_pkg::PRESSED_DEPTH
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  hst_in_if.sink                        in_i,
  hst_out_if.source                     out_o,
  input  wire                           cfg_we_i,
  input  wire [hst_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [hst_pkg::CFG_W-1:0]      cfg_wdata_i
);
  import hst_pkg::*;

  localparam int AW = $clog2(PRESSED_DEPTH);

  cfg_t          cfg_q;

  // engine to store
  pk_cmd_t       pk_cmd;
  logic [AW-1:0] pk_rd_addr;
  logic [AW-1:0] pk_wr_addr;
  key_t          pk_key;
  logic          pk_valid;

  // engine result and output register
  logic          res_valid;
  logic          res_ready;
  out_item_t     res;
  logic          out_valid_q;
  out_item_t     out_item_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_VIS:   cfg_q.vis_rule   <= cfg_wdata_i[1:0];
        CFG_INIT:  cfg_q.init_sw    <= cfg_wdata_i[1:0];
        CFG_BIND0: cfg_q.binding[0] <= binding_t'(cfg_wdata_i);
        CFG_BIND1: cfg_q.binding[1] <= binding_t'(cfg_wdata_i);
        CFG_BIND2: cfg_q.binding[2] <= binding_t'(cfg_wdata_i);
        CFG_BIND3: cfg_q.binding[3] <= binding_t'(cfg_wdata_i);
        default:   ;
      endcase
    end
  end

  hst_engine #(
    .DEPTH(PRESSED_DEPTH)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (in_i.valid),
    .item_i       (in_i.item),
    .item_ready_o (in_i.ready),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .pk_cmd_o     (pk_cmd),
    .pk_rd_addr_o (pk_rd_addr),
    .pk_wr_addr_o (pk_wr_addr),
    .pk_key_i     (pk_key),
    .pk_valid_i   (pk_valid)
  );

  hst_pressed_store #(
    .DEPTH(PRESSED_DEPTH)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (pk_cmd),
    .rd_addr_i  (pk_rd_addr),
    .wr_addr_i  (pk_wr_addr),
    .rd_key_o   (pk_key),
    .rd_valid_o (pk_valid)
  );

  // output register: takes a new result when empty or being drained
  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
      if (res_valid) out_item_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.item  = out_item_q;

endmodule
`default_nettype wire
